@@ rtl/mrrg_pkg.sv @@
// ----------------------------------------------------------------------------
// mrrg_pkg
// shared types and constants of the row-budgeted lehmer random generator
// ----------------------------------------------------------------------------
`default_nettype none

package mrrg_pkg;

    localparam int SKIP_ROW_BITS_DEF = 32;
    localparam int SEED_W            = 31;
    localparam int BUDGET_W          = 10;
    localparam int CFG_ADDR_W        = 1;
    localparam int CFG_DATA_W        = 31;

    localparam logic [SEED_W-1:0]   LEHMER_MUL = 31'd16807;
    localparam logic [SEED_W-1:0]   LEHMER_MOD = 31'h7FFF_FFFF;

    localparam logic [CFG_ADDR_W-1:0] REG_START_SEED    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DRAWS_PER_ROW = 1'b1;

    localparam logic [1:0] MODE_NEXT   = 2'd0;
    localparam logic [1:0] MODE_RANGE  = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_SKIP   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BUDGET = 2'd1;
    localparam logic [1:0] ST_ORDER  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [31:0]        rows_to_skip;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_CONST,
        OP_MUL_SEED_M,
        OP_MUL_M_M,
        OP_MUL_SPAN,
        OP_FOLD,
        OP_CORR,
        OP_WR_SEED,
        OP_DRAW_WB,
        OP_WR_M,
        OP_LOAD_LEFT,
        OP_LOAD_ROWS,
        OP_CLR_USED,
        OP_OUT
    } t_dp_op;

    typedef enum logic [1:0] {
        SEL_SEED,
        SEL_RANGE,
        SEL_BUDGET,
        SEL_ORDER
    } t_out_sel;

    typedef struct packed {
        t_dp_op   op;
        t_out_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       order_err;
        logic       budget_err;
        logic       used_nz;
        logic       cnt_zero;
        logic       cnt_bit0;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/minstd_row_random_generator_unit.sv @@
// ----------------------------------------------------------------------------
// minstd_row_random_generator_unit
// lehmer x*16807 mod 2^31-1 generator with a per-row draw budget
// ----------------------------------------------------------------------------
// input channel carries mode, range bounds and row skip count; output channel
// returns value and status, one transfer per input transfer, in order.
// config port: index 0 loads the seed and clears the row count, index 1 sets
// the draws per row; write only while no transfer is in flight.
// finish row and skip rows run square-and-multiply over the jump count, one
// exponent bit per loop pass, sharing a single 31x32 multiplier and a
// three-step mod 2^31-1 folder; a skip handles a jump count of up to 42
// bits, and a partly used row is finished first.
// one item is processed at a time; a new item is taken once the previous one
// has reached the output register, even if the receiver has not taken it.
// when the receiver stalls, a finished item waits in its last step.
// reset: seed 1, draws per row 1, row count 0, no pending output.
// ----------------------------------------------------------------------------
`default_nettype none

module minstd_row_random_generator_unit #(
    parameter int SKIP_ROW_BITS = mrrg_pkg::SKIP_ROW_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mrrg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [mrrg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire mrrg_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output mrrg_pkg::t_out_item                    o_out_item
);

    mrrg_pkg::t_dp_cmd  cmd;
    mrrg_pkg::t_dp_stat stat;

    mrrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mrrg_datapath #(
        .SKIP_ROW_BITS (SKIP_ROW_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_load   (i_in_valid && o_in_ready),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

@@ rtl/mrrg_datapath.sv @@
// ----------------------------------------------------------------------------
// mrrg_datapath
// seed, budget and jump registers, shared multiplier and mod 2^31-1 folder
// ----------------------------------------------------------------------------
`default_nettype none

module mrrg_datapath #(
    parameter int SKIP_ROW_BITS = mrrg_pkg::SKIP_ROW_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mrrg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [mrrg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_in_load,
    input  wire mrrg_pkg::t_in_item                i_in_item,
    input  wire mrrg_pkg::t_dp_cmd                 i_cmd,
    output mrrg_pkg::t_dp_stat                     o_stat,
    output mrrg_pkg::t_out_item                    o_out_item
);

    localparam int CNT_W = mrrg_pkg::BUDGET_W + SKIP_ROW_BITS;

    logic [mrrg_pkg::SEED_W-1:0]   r_seed;
    logic [mrrg_pkg::SEED_W-1:0]   r_m;
    logic [mrrg_pkg::BUDGET_W-1:0] r_dpr;
    logic [mrrg_pkg::BUDGET_W-1:0] r_used;
    logic [CNT_W-1:0]              r_cnt;
    logic [63:0]                   r_x;
    logic [32:0]                   r_q;
    mrrg_pkg::t_in_item            r_item;
    mrrg_pkg::t_out_item           r_out;

    logic [30:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_hi;
    logic [63:0] prod;
    logic [32:0] span;
    logic [63:0] x_fold;
    logic [32:0] q_fold;
    logic [mrrg_pkg::SEED_W-1:0] seed_norm;

    assign span = 33'({r_item.range_high[31], r_item.range_high}
                    - {r_item.range_low[31], r_item.range_low} + 33'd1);

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_hi = 1'b0;
        unique case (i_cmd.op)
            mrrg_pkg::OP_MUL_CONST: begin
                mul_a = r_seed;
                mul_b = {1'b0, mrrg_pkg::LEHMER_MUL};
            end
            mrrg_pkg::OP_MUL_SEED_M: begin
                mul_a = r_seed;
                mul_b = {1'b0, r_m};
            end
            mrrg_pkg::OP_MUL_M_M: begin
                mul_a = r_m;
                mul_b = {1'b0, r_m};
            end
            mrrg_pkg::OP_MUL_SPAN: begin
                mul_a  = r_seed;
                mul_b  = span[31:0];
                mul_hi = span[32];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod = ({33'd0, mul_a} * {32'd0, mul_b})
                + (mul_hi ? {1'b0, r_seed, 32'd0} : 64'd0);

    assign x_fold    = {33'd0, r_x[30:0]} + {31'd0, r_x[63:31]};
    assign q_fold    = r_q + r_x[63:31];
    assign seed_norm = (r_seed == mrrg_pkg::LEHMER_MOD) ? '0 : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 31'd1;
            r_dpr  <= 10'd1;
            r_used <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mrrg_pkg::REG_START_SEED: begin
                    r_seed <= i_cfg_wdata;
                    r_used <= '0;
                end
                mrrg_pkg::REG_DRAWS_PER_ROW: begin
                    r_dpr <= i_cfg_wdata[mrrg_pkg::BUDGET_W-1:0];
                end
                default: begin
                    r_dpr <= r_dpr;
                end
            endcase
        end else begin
            unique case (i_cmd.op)
                mrrg_pkg::OP_WR_SEED:   r_seed <= r_x[30:0];
                mrrg_pkg::OP_DRAW_WB: begin
                    r_seed <= r_x[30:0];
                    r_used <= r_used + 10'd1;
                end
                mrrg_pkg::OP_LOAD_LEFT: r_seed <= seed_norm;
                mrrg_pkg::OP_LOAD_ROWS: r_seed <= seed_norm;
                mrrg_pkg::OP_CLR_USED:  r_used <= '0;
                default: begin
                    r_used <= r_used;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_load) begin
            r_item <= i_in_item;
        end
        unique case (i_cmd.op)
            mrrg_pkg::OP_MUL_CONST, mrrg_pkg::OP_MUL_SEED_M,
            mrrg_pkg::OP_MUL_M_M, mrrg_pkg::OP_MUL_SPAN: begin
                r_x <= prod;
                r_q <= '0;
            end
            mrrg_pkg::OP_FOLD: begin
                r_x <= x_fold;
                r_q <= q_fold;
            end
            mrrg_pkg::OP_CORR: begin
                if (r_x[30:0] == mrrg_pkg::LEHMER_MOD) begin
                    r_x <= '0;
                    r_q <= r_q + 33'd1;
                end
            end
            mrrg_pkg::OP_WR_M: begin
                r_m   <= r_x[30:0];
                r_cnt <= r_cnt >> 1;
            end
            mrrg_pkg::OP_LOAD_LEFT: begin
                r_m   <= mrrg_pkg::LEHMER_MUL;
                r_cnt <= (r_dpr > r_used) ? CNT_W'(r_dpr - r_used) : '0;
            end
            mrrg_pkg::OP_LOAD_ROWS: begin
                r_m   <= mrrg_pkg::LEHMER_MUL;
                r_cnt <= {{SKIP_ROW_BITS{1'b0}}, r_dpr}
                       * {{mrrg_pkg::BUDGET_W{1'b0}},
                          r_item.rows_to_skip[SKIP_ROW_BITS-1:0]};
            end
            mrrg_pkg::OP_OUT: begin
                unique case (i_cmd.sel)
                    mrrg_pkg::SEL_SEED: begin
                        r_out.value  <= {1'b0, r_seed};
                        r_out.status <= mrrg_pkg::ST_OK;
                    end
                    mrrg_pkg::SEL_RANGE: begin
                        r_out.value  <= r_item.range_low + $signed(r_q[31:0]);
                        r_out.status <= mrrg_pkg::ST_OK;
                    end
                    mrrg_pkg::SEL_BUDGET: begin
                        r_out.value  <= '0;
                        r_out.status <= mrrg_pkg::ST_BUDGET;
                    end
                    mrrg_pkg::SEL_ORDER: begin
                        r_out.value  <= '0;
                        r_out.status <= mrrg_pkg::ST_ORDER;
                    end
                    default: begin
                        r_out.value  <= '0;
                        r_out.status <= mrrg_pkg::ST_OK;
                    end
                endcase
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    always_comb begin
        o_stat.mode       = r_item.mode;
        o_stat.order_err  = (r_item.mode == mrrg_pkg::MODE_RANGE)
                         && ($signed(r_item.range_high) < $signed(r_item.range_low));
        o_stat.budget_err = (r_used >= r_dpr);
        o_stat.used_nz    = (r_used != '0);
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.cnt_bit0   = r_cnt[0];
    end

    assign o_out_item = r_out;

endmodule

`default_nettype wire

@@ rtl/mrrg_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrrg_ctrl
// sequencer for draws, modular reduction steps and square-and-multiply jumps
// ----------------------------------------------------------------------------
`default_nettype none

module mrrg_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire mrrg_pkg::t_dp_stat   i_stat,
    output mrrg_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FOLD1,
        S_FOLD2,
        S_FOLD3,
        S_CORR,
        S_DRAW_WB,
        S_SPAN,
        S_JUMP,
        S_JSEED,
        S_JSQ,
        S_JM,
        S_ROWS,
        S_FINISH,
        S_OUT
    } t_state;

    t_state             r_state, n_state;
    t_state             r_ret, n_ret;
    t_state             r_after, n_after;
    mrrg_pkg::t_out_sel r_sel, n_sel;
    logic               r_out_valid, n_out_valid;
    logic               slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_after     = r_after;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = mrrg_pkg::OP_NONE;
        o_cmd.sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_stat.mode == mrrg_pkg::MODE_FINISH) begin
                    o_cmd.op = mrrg_pkg::OP_LOAD_LEFT;
                    n_after  = S_FINISH;
                    n_state  = S_JUMP;
                end else if (i_stat.mode == mrrg_pkg::MODE_SKIP) begin
                    if (i_stat.used_nz) begin
                        o_cmd.op = mrrg_pkg::OP_LOAD_LEFT;
                        n_after  = S_ROWS;
                        n_state  = S_JUMP;
                    end else begin
                        n_state = S_ROWS;
                    end
                end else if (i_stat.order_err) begin
                    n_sel   = mrrg_pkg::SEL_ORDER;
                    n_state = S_OUT;
                end else if (i_stat.budget_err) begin
                    n_sel   = mrrg_pkg::SEL_BUDGET;
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = mrrg_pkg::OP_MUL_CONST;
                    n_ret    = S_DRAW_WB;
                    n_state  = S_FOLD1;
                end
            end
            S_FOLD1: begin
                o_cmd.op = mrrg_pkg::OP_FOLD;
                n_state  = S_FOLD2;
            end
            S_FOLD2: begin
                o_cmd.op = mrrg_pkg::OP_FOLD;
                n_state  = S_FOLD3;
            end
            S_FOLD3: begin
                o_cmd.op = mrrg_pkg::OP_FOLD;
                n_state  = S_CORR;
            end
            S_CORR: begin
                o_cmd.op = mrrg_pkg::OP_CORR;
                n_state  = r_ret;
            end
            S_DRAW_WB: begin
                o_cmd.op = mrrg_pkg::OP_DRAW_WB;
                if (i_stat.mode == mrrg_pkg::MODE_NEXT) begin
                    n_sel   = mrrg_pkg::SEL_SEED;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                o_cmd.op = mrrg_pkg::OP_MUL_SPAN;
                n_sel    = mrrg_pkg::SEL_RANGE;
                n_ret    = S_OUT;
                n_state  = S_FOLD1;
            end
            S_JUMP: begin
                priority if (i_stat.cnt_zero) begin
                    n_state = r_after;
                end else if (i_stat.cnt_bit0) begin
                    o_cmd.op = mrrg_pkg::OP_MUL_SEED_M;
                    n_ret    = S_JSEED;
                    n_state  = S_FOLD1;
                end else begin
                    o_cmd.op = mrrg_pkg::OP_MUL_M_M;
                    n_ret    = S_JM;
                    n_state  = S_FOLD1;
                end
            end
            S_JSEED: begin
                o_cmd.op = mrrg_pkg::OP_WR_SEED;
                n_state  = S_JSQ;
            end
            S_JSQ: begin
                o_cmd.op = mrrg_pkg::OP_MUL_M_M;
                n_ret    = S_JM;
                n_state  = S_FOLD1;
            end
            S_JM: begin
                o_cmd.op = mrrg_pkg::OP_WR_M;
                n_state  = S_JUMP;
            end
            S_ROWS: begin
                o_cmd.op = mrrg_pkg::OP_LOAD_ROWS;
                n_after  = S_FINISH;
                n_state  = S_JUMP;
            end
            S_FINISH: begin
                o_cmd.op = mrrg_pkg::OP_CLR_USED;
                n_sel    = mrrg_pkg::SEL_SEED;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.op    = mrrg_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_after     <= S_IDLE;
            r_sel       <= mrrg_pkg::SEL_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_after     <= n_after;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted transfer not decoded");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result overwrote a pending transfer");

    a_jump_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_JM) |=> (r_state == S_JUMP))
        else $error("jump loop left after square step");

endmodule

`default_nettype wire

@@ sim/mrrg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrrg_checker
// predicts and checks every result of the row-budgeted lehmer generator
// ----------------------------------------------------------------------------
// watches the config port and both channels, keeps its own copy of seed,
// row count and budget, and compares each output transfer with the oldest
// predicted result. mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module mrrg_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mrrg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [mrrg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire mrrg_pkg::t_in_item                i_in_item,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire mrrg_pkg::t_out_item               i_out_item,
    output int                                     o_errors,
    output int                                     o_pending,
    output int                                     o_checked
);
    import mrrg_pkg::*;

    localparam logic [63:0] MOD64 = 64'h7FFF_FFFF;

    logic [30:0] seed_q;
    logic [9:0]  used_q;
    logic [9:0]  budget_q;
    t_out_item   want_q[$];

    function automatic logic [30:0] modmul(input logic [30:0] a, input logic [30:0] b);
        logic [63:0] p;
        p = {33'd0, a} * {33'd0, b};
        return 31'(p % MOD64);
    endfunction

    function automatic logic [30:0] jump_seed(input logic [30:0] s0, input logic [63:0] cnt);
        logic [30:0] m;
        logic [30:0] s;
        logic [63:0] c;
        m = LEHMER_MUL;
        s = 31'({33'd0, s0} % MOD64);
        c = cnt;
        while (c != 0) begin
            if (c[0]) s = modmul(s, m);
            c = c >> 1;
            m = modmul(m, m);
        end
        return s;
    endfunction

    function automatic void close_row();
        logic [63:0] left;
        left = (budget_q > used_q) ? 64'(budget_q - used_q) : 64'd0;
        seed_q = jump_seed(seed_q, left);
        used_q = '0;
    endfunction

    function automatic t_out_item draw_result(input t_in_item it);
        t_out_item   r;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic [63:0] span;
        logic [63:0] q;
        logic [63:0] rows;
        r.value  = '0;
        r.status = ST_OK;
        lo = 64'(it.range_low);
        hi = 64'(it.range_high);
        case (it.mode)
            MODE_NEXT, MODE_RANGE: begin
                if (it.mode == MODE_RANGE && hi < lo) begin
                    r.status = ST_ORDER;
                end else if (used_q >= budget_q) begin
                    r.status = ST_BUDGET;
                end else begin
                    seed_q = modmul(31'({33'd0, seed_q} % MOD64), LEHMER_MUL);
                    used_q = used_q + 10'd1;
                    if (it.mode == MODE_NEXT) begin
                        r.value = {1'b0, seed_q};
                    end else begin
                        span = 64'(hi - lo) + 64'd1;
                        q = ({33'd0, seed_q} * span) / MOD64;
                        r.value = 32'(lo + $signed(q));
                    end
                end
            end
            MODE_FINISH: begin
                close_row();
                r.value = {1'b0, seed_q};
            end
            default: begin
                rows = {32'd0, it.rows_to_skip} & ((64'd1 << SKIP_ROW_BITS_DEF) - 64'd1);
                if (used_q > 0) close_row();
                seed_q = jump_seed(seed_q, 64'(budget_q) * rows);
                used_q = '0;
                r.value = {1'b0, seed_q};
            end
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("[%0t] %s: got %0h expected %0h", $time, what, got, exp);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            seed_q   = 31'd1;
            used_q   = '0;
            budget_q = 10'd1;
            want_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_START_SEED) begin
                    seed_q = i_cfg_wdata[30:0];
                    used_q = '0;
                end else if (i_cfg_addr == REG_DRAWS_PER_ROW) begin
                    budget_q = i_cfg_wdata[9:0];
                end
            end
            if (i_in_valid && i_in_ready) want_q.push_back(draw_result(i_in_item));
            if (i_out_valid && i_out_ready) begin
                if (want_q.size() == 0) begin
                    report("unexpected transfer", i_out_item.value, 32'd0);
                end else begin
                    w = want_q.pop_front();
                    if (i_out_item.value !== w.value) report("value", i_out_item.value, w.value);
                    if (i_out_item.status !== w.status) report("status", 32'(i_out_item.status), 32'(w.status));
                    o_checked++;
                end
            end
        end
        o_pending = want_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end
endmodule

@@ sim/tb_minstd_row_random_generator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_minstd_row_random_generator_unit
// stimulus and verdict for the row-budgeted lehmer generator
// ----------------------------------------------------------------------------
// directed items cover bound extremes, every mode, budget and order errors,
// zero budget, degenerate seeds and lowered budgets; then random phases with
// varying seed and budget, random gaps on both channels and one long output
// stall. checking lives in mrrg_checker.
// ----------------------------------------------------------------------------
module tb_minstd_row_random_generator_unit;
    import mrrg_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    int         errors;
    int         pending;
    int         checked;
    bit         calm = 1'b0;
    bit         hold_req = 1'b0;
    int         sent = 0;
    int         cfg_writes = 0;

    always #10 i_clk = ~i_clk;

    minstd_row_random_generator_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    mrrg_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    task automatic send(input logic [1:0] mode, input logic [31:0] lo, input logic [31:0] hi,
                        input logic [31:0] rows);
        if (!calm && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{mode: mode, range_low: lo, range_high: hi, rows_to_skip: rows};
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    // wait for the block to drain before touching config
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [30:0] data);
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] rows;
        pick = $urandom_range(99);
        a = $urandom;
        b = $urandom;
        if ($urandom_range(3) != 0 && $signed(b) < $signed(a)) {a, b} = {b, a};
        if ($urandom_range(9) == 0) rows = $urandom;
        else rows = $urandom_range(0, 40);
        if (pick < 35) send(MODE_NEXT, a, b, rows);
        else if (pick < 75) send(MODE_RANGE, a, b, rows);
        else if (pick < 88) send(MODE_FINISH, a, b, rows);
        else send(MODE_SKIP, a, b, rows);
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(posedge i_clk);
            end
            out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
        end
    end

    initial begin
        #(200_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int ph;
        int k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with reset config
        send(MODE_NEXT, 32'h0, 32'h0, 32'h0);
        send(MODE_NEXT, 32'h0, 32'h0, 32'h0);
        send(MODE_FINISH, 32'h0, 32'h0, 32'h0);
        send(MODE_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send(MODE_RANGE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send(MODE_SKIP, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        write_reg(REG_DRAWS_PER_ROW, 31'd1023);
        write_reg(REG_START_SEED, 31'h7FFF_FFFE);
        send(MODE_RANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send(MODE_RANGE, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send(MODE_NEXT, 32'h0, 32'h0, 32'h0);
        send(MODE_SKIP, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send(MODE_SKIP, 32'h0, 32'h0, 32'h0);
        send(MODE_NEXT, 32'h0, 32'h0, 32'h0);
        write_reg(REG_DRAWS_PER_ROW, 31'd1);
        send(MODE_FINISH, 32'h0, 32'h0, 32'h0);
        write_reg(REG_DRAWS_PER_ROW, 31'd0);
        send(MODE_NEXT, 32'h0, 32'h0, 32'h0);
        send(MODE_RANGE, 32'h0, 32'h5, 32'h0);
        send(MODE_SKIP, 32'h0, 32'h0, 32'd7);
        write_reg(REG_START_SEED, 31'h7FFF_FFFF);
        write_reg(REG_DRAWS_PER_ROW, 31'd3);
        send(MODE_NEXT, 32'h0, 32'h0, 32'h0);
        send(MODE_RANGE, 32'hFFFF_FFF0, 32'h10, 32'h0);
        send(MODE_FINISH, 32'h0, 32'h0, 32'h0);
        write_reg(REG_START_SEED, 31'd0);
        send(MODE_RANGE, 32'h12, 32'h99, 32'h0);

        // random phases with varying config
        for (ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 0)
                write_reg(REG_START_SEED, (ph == 3) ? 31'h7FFF_FFFE : 31'($urandom_range(1, 32'h7FFF_FFFE)));
            case (ph)
                1: write_reg(REG_DRAWS_PER_ROW, 31'd1023);
                4: write_reg(REG_DRAWS_PER_ROW, 31'd1);
                7: write_reg(REG_DRAWS_PER_ROW, 31'($urandom_range(0, 1023)));
                default: write_reg(REG_DRAWS_PER_ROW, 31'($urandom_range(1, 12)));
            endcase
            calm = (ph == 5);
            if (ph == 2) hold_req = 1'b1;
            for (k = 0; k < 200; k++) begin
                random_item();
                // mid-row budget changes are only legal once drained
                if (ph == 8 && k == 100) write_reg(REG_DRAWS_PER_ROW, 31'd2);
            end
            calm = 1'b0;
        end

        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (600) @(posedge i_clk);
        $display("run covered %0d items, %0d checked results, %0d config writes", sent, checked,
                 cfg_writes);
        $display("modes next, ranged, finish and skip with budgets from 0 to 1023");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
